>>> design/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, operation codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int FIELD_BITS = 63;
	localparam int WORD_BITS  = 64;
	localparam int SCAN_BITS  = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int CNT_BITS   = $clog2(FIELD_BITS);
	localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(FIELD_BITS - 1);
	localparam logic [FIELD_BITS-1:0] EXP_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - SCAN_BITS);

	typedef logic [FIELD_BITS-1:0] field_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_REDUCE = 2'd0;
	localparam op_t OP_ACC    = 2'd1;
	localparam op_t OP_SQUARE = 2'd2;

	typedef struct packed {
		logic load;
		logic mul_start;
		logic mul_step;
		logic wb;
		op_t  op;
		logic exp_shift;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_bit0;
		logic exp_last;
	} status_t;

endpackage

>>> design/modexp_dp.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Modulus register, operand registers and a shared interleaved modular
// multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module modexp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  modexp_pkg::field_t  modulus,
	input  modexp_pkg::field_t  base_value,
	input  modexp_pkg::field_t  exponent,
	input  modexp_pkg::cmd_t    cmd,
	output modexp_pkg::status_t status,
	output modexp_pkg::field_t  power_result
);
	import modexp_pkg::*;

	field_t mod_cfg_q;
	field_t mod_q;
	field_t base_q;
	field_t acc_q;
	field_t exp_q;
	field_t mcand_q;
	field_t mplier_q;
	field_t prod_q;
	field_t res_q;

	logic [FIELD_BITS+1:0] sum;
	logic [FIELD_BITS+2:0] diff1;
	logic [FIELD_BITS+2:0] diff2;
	field_t                addend;
	field_t                prod_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cfg_q <= field_t'(1);
		end else if (cfg_we) begin
			mod_cfg_q <= modulus;
		end
	end

	// one step: prod = (2*prod + bit*mcand) mod m, sum stays below 3m
	assign addend = mplier_q[FIELD_BITS-1] ? mcand_q : '0;
	assign sum    = {1'b0, prod_q, 1'b0} + {2'b00, addend};
	assign diff1  = {1'b0, sum} - {3'b000, mod_q};
	assign diff2  = {1'b0, sum} - {2'b00, mod_q, 1'b0};

	always_comb begin
		if (!diff2[FIELD_BITS+2]) begin
			prod_next = diff2[FIELD_BITS-1:0];
		end else if (!diff1[FIELD_BITS+2]) begin
			prod_next = diff1[FIELD_BITS-1:0];
		end else begin
			prod_next = sum[FIELD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q <= (mod_cfg_q == '0) ? field_t'(1) : mod_cfg_q;
			acc_q <= (mod_cfg_q > field_t'(1)) ? field_t'(1) : '0;
			exp_q <= exponent & EXP_MASK;
		end else begin
			if (cmd.exp_shift) begin
				exp_q <= exp_q >> 1;
			end
			if (cmd.wb && cmd.op == OP_ACC) begin
				acc_q <= prod_q;
			end
		end
		if (cmd.wb && (cmd.op == OP_REDUCE || cmd.op == OP_SQUARE)) begin
			base_q <= prod_q;
		end
		if (cmd.mul_start) begin
			prod_q <= '0;
			case (cmd.op)
				OP_REDUCE: begin
					mcand_q  <= field_t'(1);
					mplier_q <= base_value;
				end
				OP_ACC: begin
					mcand_q  <= base_q;
					mplier_q <= acc_q;
				end
				default: begin
					mcand_q  <= base_q;
					mplier_q <= base_q;
				end
			endcase
		end else if (cmd.mul_step) begin
			prod_q   <= prod_next;
			mplier_q <= mplier_q << 1;
		end
		if (cmd.out_load) begin
			res_q <= acc_q;
		end
	end

	assign status.exp_zero = (exp_q == '0);
	assign status.exp_bit0 = exp_q[0];
	assign status.exp_last = (exp_q[FIELD_BITS-1:1] == '0);
	assign power_result    = res_q;

endmodule

>>> design/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the initial base reduction and the square-and-multiply loop,
// and owns the request handshakes.
// ----------------------------------------------------------------------------
module modexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  modexp_pkg::status_t status,
	output modexp_pkg::cmd_t    cmd
);
	import modexp_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_WB     = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [CNT_BITS-1:0] cnt_q;
	op_t                 op_q;
	op_t                 op_d;
	logic                acc_done_q;
	logic                acc_done_d;
	logic                out_valid_q;
	logic                in_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		acc_done_d     = acc_done_q;
		cmd            = '0;
		cmd.op         = op_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.op        = OP_REDUCE;
					op_d          = OP_REDUCE;
					acc_done_d    = 1'b0;
					state_d       = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.exp_zero) begin
					state_d = S_DONE;
				end else if (status.exp_bit0 && !acc_done_q) begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_ACC;
					op_d          = OP_ACC;
					acc_done_d    = 1'b1;
					state_d       = S_MUL;
				end else if (status.exp_last) begin
					cmd.exp_shift = 1'b1;
					acc_done_d    = 1'b0;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_SQUARE;
					op_d          = OP_SQUARE;
					cmd.exp_shift = 1'b1;
					acc_done_d    = 1'b0;
					state_d       = S_MUL;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			op_q        <= OP_REDUCE;
			acc_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			op_q       <= op_d;
			acc_done_q <= acc_done_d;
			if (cmd.mul_start) begin
				cnt_q <= '0;
			end else if (cmd.mul_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |=> (state_q == S_MUL && cnt_q == '0))
		else $error("multiply did not start");

	a_mul_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && cnt_q == MUL_LAST) |=> (state_q == S_WB))
		else $error("multiply ran past its last bit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second request taken while busy");

endmodule

>>> design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Sequence: the base is reduced first, then one squaring for each exponent bit
// below the top set bit and one multiply into the accumulator for each set bit;
// an exponent of zero skips the loop after the reduction. Result stalls add to it.
// Throughput: one request at a time; the next is taken the cycle after the
// result loads, paced by the one-bit-per-cycle multiplier.
// Reset: asynchronous, modulus returns to 1 and the result register is empty.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square-and-multiply: base^exponent mod modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  modexp_pkg::field_t modulus,
	input  logic               in_valid,
	output logic               in_ready,
	input  modexp_pkg::field_t base_value,
	input  modexp_pkg::field_t exponent,
	output logic               out_valid,
	input  logic               out_ready,
	output modexp_pkg::field_t power_result
);
	import modexp_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	modexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	modexp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.modulus      (modulus),
		.base_value   (base_value),
		.exponent     (exponent),
		.cmd          (cmd),
		.status       (status),
		.power_result (power_result)
	);

endmodule

>>> tb/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the modulus, request and result channels. Each accepted request is
// turned into the expected power by square-and-multiply with exact products,
// and each result is compared in order against the oldest expected power.
// ----------------------------------------------------------------------------
module modexp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  modexp_pkg::field_t modulus,
	input  logic               in_valid,
	input  logic               in_ready,
	input  modexp_pkg::field_t base_value,
	input  modexp_pkg::field_t exponent,
	input  logic               out_valid,
	input  logic               out_ready,
	input  modexp_pkg::field_t power_result,
	output int                 fails,
	output int                 pending
);
	import modexp_pkg::*;

	field_t cur_modulus;
	field_t power_due[$];
	int     bad;

	function automatic field_t modpow(input field_t b, input field_t e, input field_t m);
		logic [2*FIELD_BITS-1:0] wide;
		field_t                  mm;
		field_t                  acc;
		field_t                  run;
		mm = (m == '0) ? field_t'(1) : m;
		run = b % mm;
		acc = field_t'(1) % mm;
		for (int i = 0; i < SCAN_BITS; i++) begin
			if (e[i]) begin
				wide = (2*FIELD_BITS)'(acc) * (2*FIELD_BITS)'(run);
				acc = field_t'(wide % (2*FIELD_BITS)'(mm));
			end
			wide = (2*FIELD_BITS)'(run) * (2*FIELD_BITS)'(run);
			run = field_t'(wide % (2*FIELD_BITS)'(mm));
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_t want;
		if (!arst_n) begin
			cur_modulus <= field_t'(1);
			power_due.delete();
			bad = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (power_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected result: got %h", power_result);
				end else begin
					want = power_due.pop_front();
					if (power_result !== want) begin
						bad++;
						if (bad <= 10)
							$display("power_result mismatch: expected %h, got %h",
								want, power_result);
					end
				end
			end
			if (in_valid && in_ready)
				power_due.insert(power_due.size(),
					modpow(base_value, exponent, cur_modulus));
			if (cfg_valid && cfg_ready)
				cur_modulus <= modulus;
			fails <= bad;
			pending <= power_due.size();
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives requests through several modulus settings: directed corner cases
// first, then random bases and exponents, with random gaps on the request
// side and random stalls on the result side. The checker predicts results.
// ----------------------------------------------------------------------------
module testbench;
	import modexp_pkg::*;

	localparam int     IDLE_LIMIT = 40000;
	localparam field_t FIELD_MAX  = '1;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	field_t modulus = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	field_t base_value = '0;
	field_t exponent = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	field_t power_result;
	int     fails;
	int     pending;
	logic   no_stall = 1'b0;
	int     ready_left = 0;
	int     stall_len;
	int     idle_cycles = 0;

	modular_exponentiation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.modulus      (modulus),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.base_value   (base_value),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.power_result (power_result)
	);

	modexp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.modulus      (modulus),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.base_value   (base_value),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.power_result (power_result),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic field_t rand_field();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[FIELD_BITS-1:0];
	endfunction

	function automatic int gap_len();
		int r;
		if (no_stall)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 250);
	endfunction

	// result-side stalls
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else if (no_stall || !out_ready) begin
			out_ready <= 1'b1;
			ready_left <= $urandom_range(0, 15);
		end else begin
			stall_len = gap_len();
			if (stall_len > 0) begin
				out_ready <= 1'b0;
				ready_left <= stall_len - 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(input field_t b, input field_t e);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		base_value <= b;
		exponent <= e;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_modulus(input field_t m);
		wait_drained();
		cfg_valid <= 1'b1;
		modulus <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic field_t rand_modulus();
		case ($urandom_range(0, 3))
			0: return rand_field();
			1: return field_t'($urandom());
			2: return field_t'($urandom_range(2, 300));
			default: return FIELD_MAX - field_t'($urandom_range(0, 1000));
		endcase
	endfunction

	task automatic random_requests(input int n);
		field_t b;
		field_t e;
		int     r;
		no_stall <= ($urandom_range(0, 3) == 0);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				b = rand_field();
			else if (r < 70)
				b = '0;
			else if (r < 80)
				b = field_t'($urandom_range(1, 3));
			else if (r < 88)
				b = FIELD_MAX;
			else
				b = field_t'($urandom_range(0, 1000));
			// mostly short exponents, a few full width
			r = $urandom_range(0, 99);
			if (r < 10)
				e = rand_field();
			else if (r < 14)
				e = FIELD_MAX;
			else if (r < 18)
				e = '0;
			else
				e = rand_field() >> (FIELD_BITS - $urandom_range(1, 12));
			send_request(b, e);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// modulus at its reset value of one
		send_request('0, '0);
		send_request(FIELD_MAX, field_t'(3));
		random_requests(8);

		// zero modulus behaves as one
		write_modulus('0);
		send_request(field_t'(7), '0);
		send_request(field_t'(123), field_t'(9));
		random_requests(8);

		write_modulus(FIELD_MAX);
		send_request('0, '0);
		send_request('0, field_t'(1));
		send_request('0, FIELD_MAX);
		send_request(FIELD_MAX, field_t'(1));
		send_request(FIELD_MAX - field_t'(1), FIELD_MAX);
		send_request(field_t'(1), FIELD_MAX);
		send_request(field_t'(2), field_t'(62));
		send_request(field_t'(2), field_t'(63));
		send_request(field_t'(123456789), field_t'(2));
		send_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
		send_request(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		random_requests(14);

		write_modulus(field_t'(1));
		random_requests(8);

		write_modulus(field_t'(2));
		send_request(field_t'(3), FIELD_MAX);
		send_request(field_t'(4), field_t'(5));
		random_requests(8);

		write_modulus(field_t'(97));
		send_request(field_t'(96), field_t'(2));
		send_request(field_t'(97), field_t'(5));
		random_requests(8);

		write_modulus(field_t'(1) << (FIELD_BITS - 1));
		send_request(field_t'(3), FIELD_MAX >> 1);
		random_requests(8);

		repeat (4) begin
			write_modulus(rand_modulus());
			random_requests(10);
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
design/modexp_pkg.sv
design/modexp_dp.sv
design/modexp_ctrl.sv
design/modular_exponentiation.sv
tb/modexp_checker.sv
tb/testbench.sv
